// ----- sv/pid_controller_clamped_unit_macros.svh -----
// Assertion macros shared by the PID block.
`ifndef PID_CONTROLLER_CLAMPED_UNIT_MACROS_SVH
`define PID_CONTROLLER_CLAMPED_UNIT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define PIDC_ASSERT_NOW(label, ck, rn, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define PIDC_ASSERT_NEXT(label, ck, rn, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/pidc_pkg.sv -----
package pidc_pkg;

  // Data word and fixed-point format (signed Q16.16)
  localparam int DW        = 32;
  localparam int FRAC      = 16;
  localparam int CFG_IDX_W = 3;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROP_GAIN  = 3'd0,
    REG_INTEG_GAIN = 3'd1,
    REG_DERIV_GAIN = 3'd2,
    REG_INTEG_MIN  = 3'd3,
    REG_INTEG_MAX  = 3'd4,
    REG_OUT_MIN    = 3'd5,
    REG_OUT_MAX    = 3'd6
  } cfg_reg_t;

  // Register reset values
  localparam logic signed [DW-1:0] RST_PROP_GAIN  = 32'sd57016320;
  localparam logic signed [DW-1:0] RST_INTEG_GAIN = 32'sd655;
  localparam logic signed [DW-1:0] RST_DERIV_GAIN = 32'sd16384000;
  localparam logic signed [DW-1:0] RST_INTEG_MIN  = -32'sd6553600;
  localparam logic signed [DW-1:0] RST_INTEG_MAX  = 32'sd6553600;
  localparam logic signed [DW-1:0] RST_OUT_MIN    = -32'sd5701632;
  localparam logic signed [DW-1:0] RST_OUT_MAX    = 32'sd5701632;

  // Gains and limits as seen by the datapath
  typedef struct packed {
    logic signed [DW-1:0] prop_gain;
    logic signed [DW-1:0] integ_gain;
    logic signed [DW-1:0] deriv_gain;
    logic signed [DW-1:0] integ_min;
    logic signed [DW-1:0] integ_max;
    logic signed [DW-1:0] out_min;
    logic signed [DW-1:0] out_max;
  } cfg_t;

  // Loop state carried between samples
  typedef struct packed {
    logic signed [DW-1:0] integ_acc;
    logic signed [DW-1:0] last_error;
    logic signed [DW-1:0] last_sample;
  } loop_state_t;

endpackage

// ----- sv/pid_controller_clamped_unit.sv -----
// Channel | Direction | Handshake           | Beat contents
// in_     | input     | in_valid/in_stall   | in_target, in_sample
// out_    | output    | out_valid/out_stall | out_drive
// cfg_    | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// One beat per cycle sustained while out_stall is low; a beat's drive passes
// the input register, one datapath pass and the output register.
// Integrator and previous error/sample update in that same pass.
// Reset (rst_n low, synchronous) loads default gains and limits and zeroes
// the loop state. A held out_stall stalls the output register, then the
// input register; in_stall rises only when both are full.
`include "pid_controller_clamped_unit_macros.svh"

module pid_controller_clamped_unit (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [pidc_pkg::DW-1:0]        in_target,
  input  logic signed [pidc_pkg::DW-1:0]        in_sample,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [pidc_pkg::DW-1:0]        out_drive,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [pidc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [pidc_pkg::DW-1:0]               cfg_data
);

  pidc_pkg::cfg_t                    cfg_r;
  pidc_pkg::loop_state_t             state_r;
  pidc_pkg::loop_state_t             state_nxt;
  logic                              s1_valid_r;
  logic signed [pidc_pkg::DW-1:0]    s1_target_r;
  logic signed [pidc_pkg::DW-1:0]    s1_sample_r;
  logic                              out_valid_r;
  logic signed [pidc_pkg::DW-1:0]    out_drive_r;
  logic signed [pidc_pkg::DW-1:0]    drive_nxt;
  logic                              advance;
  logic                              in_take;

  // Handshake control
  assign advance   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !advance;
  assign in_take   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_drive = out_drive_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.prop_gain  <= pidc_pkg::RST_PROP_GAIN;
      cfg_r.integ_gain <= pidc_pkg::RST_INTEG_GAIN;
      cfg_r.deriv_gain <= pidc_pkg::RST_DERIV_GAIN;
      cfg_r.integ_min  <= pidc_pkg::RST_INTEG_MIN;
      cfg_r.integ_max  <= pidc_pkg::RST_INTEG_MAX;
      cfg_r.out_min    <= pidc_pkg::RST_OUT_MIN;
      cfg_r.out_max    <= pidc_pkg::RST_OUT_MAX;
    end else if (cfg_valid && cfg_ready) begin
      case (pidc_pkg::cfg_reg_t'(cfg_index))
        pidc_pkg::REG_PROP_GAIN:  cfg_r.prop_gain  <= cfg_data;
        pidc_pkg::REG_INTEG_GAIN: cfg_r.integ_gain <= cfg_data;
        pidc_pkg::REG_DERIV_GAIN: cfg_r.deriv_gain <= cfg_data;
        pidc_pkg::REG_INTEG_MIN:  cfg_r.integ_min  <= cfg_data;
        pidc_pkg::REG_INTEG_MAX:  cfg_r.integ_max  <= cfg_data;
        pidc_pkg::REG_OUT_MIN:    cfg_r.out_min    <= cfg_data;
        pidc_pkg::REG_OUT_MAX:    cfg_r.out_max    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_target_r <= in_target;
      s1_sample_r <= in_sample;
    end
  end

  pidc_core u_core (
    .cfg       (cfg_r),
    .state     (state_r),
    .target    (s1_target_r),
    .sample    (s1_sample_r),
    .state_nxt (state_nxt),
    .drive     (drive_nxt)
  );

  // Loop state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (advance) begin
        state_r <= state_nxt;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_drive_r <= drive_nxt;
    end
  end

  // Checks
  `PIDC_ASSERT_NOW(a_drive_in_range, clk, rst_n,
    s1_valid_r && (cfg_r.out_min <= cfg_r.out_max),
    (drive_nxt >= cfg_r.out_min) && (drive_nxt <= cfg_r.out_max),
    "drive outside output limits")
  `PIDC_ASSERT_NOW(a_integ_in_range, clk, rst_n,
    s1_valid_r && (cfg_r.integ_min <= cfg_r.integ_max),
    (state_nxt.integ_acc >= cfg_r.integ_min) && (state_nxt.integ_acc <= cfg_r.integ_max),
    "integrator outside its limits")
  `PIDC_ASSERT_NEXT(a_advance_shows, clk, rst_n,
    advance,
    out_valid_r && (state_r.last_sample == $past(s1_sample_r)),
    "advanced beat not registered")

endmodule

// ----- sv/pidc_core.sv -----
// One PID update: error, three products, integrator clamp, output clamp.
module pidc_core (
  input  pidc_pkg::cfg_t                      cfg,
  input  pidc_pkg::loop_state_t               state,
  input  logic signed [pidc_pkg::DW-1:0]      target,
  input  logic signed [pidc_pkg::DW-1:0]      sample,
  output pidc_pkg::loop_state_t               state_nxt,
  output logic signed [pidc_pkg::DW-1:0]      drive
);

  localparam int DW = pidc_pkg::DW;
  localparam int FR = pidc_pkg::FRAC;

  logic signed [DW:0]        diff;
  logic signed [DW-1:0]      err;
  logic signed [DW:0]        esum;
  logic signed [DW:0]        sdiff;
  logic signed [2*DW-1:0]    prod_p;
  logic signed [2*DW:0]      prod_i;
  logic signed [2*DW:0]      prod_d;
  logic signed [2*DW-FR-1:0] prop_q;
  logic signed [2*DW-FR:0]   inc_q;
  logic signed [2*DW-FR:0]   der_q;
  logic signed [2*DW-FR+1:0] acc_sum;
  logic signed [DW-1:0]      acc_clamp;
  logic signed [2*DW-FR+2:0] drv_sum;

  // Saturated error
  assign diff = (DW+1)'(target) - (DW+1)'(sample);
  always_comb begin
    if (diff[DW] != diff[DW-1]) begin
      err = diff[DW] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
    end else begin
      err = diff[DW-1:0];
    end
  end

  // Trapezoid error sum and measurement change, kept at full width
  assign esum  = (DW+1)'(err) + (DW+1)'(state.last_error);
  assign sdiff = (DW+1)'(sample) - (DW+1)'(state.last_sample);

  // Exact products, floor shift by the fraction bits
  assign prod_p = (2*DW)'(cfg.prop_gain) * (2*DW)'(err);
  assign prod_i = (2*DW+1)'(cfg.integ_gain) * (2*DW+1)'(esum);
  assign prod_d = (2*DW+1)'(cfg.deriv_gain) * (2*DW+1)'(sdiff);
  assign prop_q = prod_p[2*DW-1:FR];
  assign inc_q  = prod_i[2*DW:FR];
  assign der_q  = prod_d[2*DW:FR];

  // Integrator with anti-windup clamp; upper limit tested first
  assign acc_sum = (2*DW-FR+2)'(state.integ_acc) + (2*DW-FR+2)'(inc_q);
  always_comb begin
    if (acc_sum > (2*DW-FR+2)'(cfg.integ_max)) begin
      acc_clamp = cfg.integ_max;
    end else if (acc_sum < (2*DW-FR+2)'(cfg.integ_min)) begin
      acc_clamp = cfg.integ_min;
    end else begin
      acc_clamp = acc_sum[DW-1:0];
    end
  end

  // P + I - D, then output clamp
  assign drv_sum = (2*DW-FR+3)'(prop_q) + (2*DW-FR+3)'(acc_clamp)
                 - (2*DW-FR+3)'(der_q);
  always_comb begin
    if (drv_sum > (2*DW-FR+3)'(cfg.out_max)) begin
      drive = cfg.out_max;
    end else if (drv_sum < (2*DW-FR+3)'(cfg.out_min)) begin
      drive = cfg.out_min;
    end else begin
      drive = drv_sum[DW-1:0];
    end
  end

  assign state_nxt.integ_acc   = acc_clamp;
  assign state_nxt.last_error  = err;
  assign state_nxt.last_sample = sample;

endmodule
